>>> rtl/core/c2dv_pkg.sv
// shared constants for the conv2d valid multi-filter core
package c2dv_pkg;
  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;
  localparam int PIX_W = 16;
  localparam int ACC_W = 40;
  localparam int PROD_W = 32;
endpackage

>>> rtl/core/c2dv_mac.sv
// registered 25-tap multiply and adder tree for one filter per cycle
module c2dv_mac #(
  parameter int TAPS = 25
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [c2dv_pkg::PIX_W-1:0] win [TAPS],
  input  logic signed [c2dv_pkg::PIX_W-1:0] wgt [TAPS],
  input  logic signed [c2dv_pkg::PIX_W-1:0] bias,
  output logic                           out_valid,
  output logic signed [c2dv_pkg::ACC_W-1:0] sum
);
  localparam int GRP = 5;
  localparam int NG = (TAPS + GRP - 1) / GRP;

  logic signed [c2dv_pkg::PROD_W-1:0] prod [TAPS];
  logic signed [c2dv_pkg::ACC_W-1:0]  bias_q;
  logic signed [c2dv_pkg::ACC_W-1:0]  bias_qq;
  logic signed [c2dv_pkg::ACC_W-1:0]  psum [NG];
  logic signed [c2dv_pkg::ACC_W-1:0]  psum_next [NG];
  logic                               prod_valid;
  logic                               psum_valid;
  logic signed [c2dv_pkg::ACC_W-1:0]  total;

  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) prod[i] <= win[i] * wgt[i];
    bias_q <= {{(c2dv_pkg::ACC_W-c2dv_pkg::PIX_W-12){bias[c2dv_pkg::PIX_W-1]}}, bias, 12'd0};
    bias_qq <= bias_q;
    for (int g = 0; g < NG; g++) psum[g] <= psum_next[g];
    if (rst) begin
      prod_valid <= 1'b0;
      psum_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      psum_valid <= prod_valid;
      out_valid  <= psum_valid;
    end
  end

  // partial sums over groups of taps
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      psum_next[g] = '0;
      for (int j = 0; j < GRP; j++)
        if (g * GRP + j < TAPS)
          psum_next[g] = psum_next[g] + c2dv_pkg::ACC_W'(prod[g * GRP + j]);
    end
  end

  always_comb begin
    total = bias_qq;
    for (int g = 0; g < NG; g++)
      total = total + psum[g];
  end

  always_ff @(posedge clk) sum <= total;
endmodule

>>> rtl/core/conv2d_valid_multi_filter_core.sv
// top level: valid 2-d convolution, line store memory, window and filter sequencing
// Weights and biases are written in the accepting cycle, and a pixel outside a full window
// is handled by the accepting cycle, which reads the line store, and the S_READ state, which
// shifts the window and writes the line store back. A pixel that completes a window then
// issues one filter per cycle to the 25-tap multiply unit, and each result passes through
// the product, partial-sum and sum registers and the result queue before it reaches the
// output. The next word is accepted only once every result of the pixel has been taken by
// the receiver, so a receiver stall delays it. The line store is cleared after reset by a
// sweep over every entry, during which no word is accepted.
module conv2d_valid_multi_filter_core #(
  parameter int IMAGE_WIDTH  = 28,
  parameter int KERNEL_SIZE  = 5,
  parameter int FILTER_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  weight_addr,
  input  logic signed [15:0] data_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  filter_num,
  output logic [4:0]  out_row,
  output logic [4:0]  out_col,
  output logic [12:0] flat_index,
  output logic signed [39:0] result_value,
  output logic        last_of_run
);
  localparam int K = KERNEL_SIZE;
  localparam int KK = K * K;
  localparam int OUT_DIM = IMAGE_WIDTH - K + 1;
  localparam int NW = FILTER_COUNT * KK;
  localparam int LR = (K > 1) ? K - 1 : 1;
  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int FW = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
  localparam int TW = (KK > 1) ? $clog2(KK) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0] state;
  logic [KK*16-1:0] wstore [FILTER_COUNT];
  logic signed [15:0] bstore [FILTER_COUNT];
  logic [LR*16-1:0] line_mem [IMAGE_WIDTH];
  logic [LR*16-1:0] line_rd;
  logic signed [15:0] win [KK];
  logic signed [15:0] wsel [KK];
  logic signed [15:0] bsel;
  logic [FW-1:0] wfilt;
  logic [TW-1:0] wtap;
  logic [CW-1:0] prow, pcol, clr;
  logic signed [15:0] pix;
  logic [FW-1:0] fcnt;
  logic [4:0] orow, ocol;
  logic issue;
  logic [FW:0] pend;
  logic mac_ov;
  logic signed [39:0] mac_sum;
  logic [FW-1:0] ofilt;
  logic [FW:0] fifo_free;

  // result queue of FILTER_COUNT entries and filter read counter; input back-off keeps it from overflowing
  logic [FW-1:0] rcnt;
  logic signed [39:0] rq [FILTER_COUNT];
  logic [FW:0] rq_n;
  logic [FW-1:0] rq_rd, rq_wr;

  assign in_ready = (state == S_IDLE);
  wire acc = in_valid && in_ready;
  wire in_window = (prow >= CW'(K-1)) && (pcol >= CW'(K-1));

  // split a weight address into filter and tap
  always_comb begin
    wfilt = '0;
    wtap = TW'(weight_addr);
    for (int f = 1; f < FILTER_COUNT; f++) begin
      if (32'(weight_addr) >= f * KK) begin
        wfilt = FW'(f);
        wtap = TW'(32'(weight_addr) - f * KK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && action == c2dv_pkg::ACT_WEIGHT && 32'(weight_addr) < NW)
      wstore[wfilt][32'(wtap)*16 +: 16] <= data_value;
    if (acc && action == c2dv_pkg::ACT_BIAS && 32'(weight_addr) < FILTER_COUNT)
      bstore[FW'(weight_addr)] <= data_value;
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) line_mem[clr] <= '0;
    else if (state == S_READ) begin
      line_mem[pcol] <= (K > 1) ? {pix, line_rd[LR*16-1:16]} : '0;
    end
    if (acc) line_rd <= line_mem[pcol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KK; i++) win[i] <= '0;
    end else if (state == S_READ) begin
      for (int r = 0; r < K; r++) begin
        for (int c = 0; c < K-1; c++) win[r*K+c] <= win[r*K+c+1];
        win[r*K+K-1] <= (r == K-1) ? pix : $signed(line_rd[r*16 +: 16]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KK; i++) wsel[i] = $signed(wstore[fcnt][i*16 +: 16]);
    bsel = bstore[fcnt];
  end

  assign issue = (state == S_RUN);

  c2dv_mac #(.TAPS(KK)) u_mac (
    .clk(clk), .rst(rst), .in_valid(issue), .win(win), .wgt(wsel), .bias(bsel),
    .out_valid(mac_ov), .sum(mac_sum)
  );

  wire pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (mac_ov) rq[rq_wr] <= mac_sum;
    if (rst) begin
      state <= S_CLEAR; clr <= '0; prow <= '0; pcol <= '0; fcnt <= '0;
      rq_n <= '0; rq_rd <= '0; rq_wr <= '0; rcnt <= '0; pend <= '0;
    end else begin
      rq_n <= rq_n + (FW+1)'(mac_ov) - (FW+1)'(pop);
      if (mac_ov) rq_wr <= (rq_wr == FW'(FILTER_COUNT-1)) ? '0 : rq_wr + 1'b1;
      if (pop) begin
        rq_rd <= (rq_rd == FW'(FILTER_COUNT-1)) ? '0 : rq_rd + 1'b1;
        rcnt  <= (rcnt == FW'(FILTER_COUNT-1)) ? '0 : rcnt + 1'b1;
      end
      pend <= pend + (FW+1)'(issue) - (FW+1)'(pop);
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CW'(IMAGE_WIDTH-1)) state <= S_IDLE;
        end
        S_IDLE: if (acc && action == c2dv_pkg::ACT_PIXEL) begin
          pix <= data_value;
          state <= S_READ;
        end
        S_READ: begin
          orow <= 5'(prow - CW'(K-1));
          ocol <= 5'(pcol - CW'(K-1));
          fcnt <= '0;
          state <= in_window ? S_RUN : S_IDLE;
          if (pcol == CW'(IMAGE_WIDTH-1)) begin
            pcol <= '0;
            prow <= (prow == CW'(IMAGE_WIDTH-1)) ? '0 : prow + 1'b1;
          end else pcol <= pcol + 1'b1;
        end
        S_RUN: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == FW'(FILTER_COUNT-1)) state <= S_DRAIN;
        end
        S_DRAIN: if (pend == '0 || (pend == 1 && pop)) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ofilt = rcnt;
  assign out_valid = (rq_n != '0);
  assign result_value = rq[rq_rd];
  assign filter_num = 3'(ofilt);
  assign out_row = orow;
  assign out_col = ocol;
  assign flat_index = 13'(32'(ofilt) * OUT_DIM * OUT_DIM + 32'(orow) * OUT_DIM + 32'(ocol));
  assign last_of_run = (ofilt == FW'(FILTER_COUNT-1));
  assign fifo_free = (FW+1)'(FILTER_COUNT) - rq_n;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rq_n <= (FW+1)'(FILTER_COUNT)) else $error("result queue overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> pend == '0) else $error("results pending while idle");
  a_free: assert property (@(posedge clk) disable iff (rst)
    mac_ov |-> fifo_free != '0) else $error("queue full on mac result");
endmodule

>>> sim/conv2d_valid_multi_filter_core_tb.sv
// testbench for the conv2d valid multi-filter core: directed table, random words, predictor check
`timescale 1ns / 1ps

module conv2d_valid_multi_filter_core_tb;

  localparam int IMG = 28;
  localparam int KS = 5;
  localparam int NF = 8;
  localparam int OD = IMG - KS + 1;
  localparam int NW = NF * KS * KS;
  localparam int LIMIT = 600000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  addr;
    logic [15:0] data;
  } word_t;

  typedef struct packed {
    logic [2:0]         filt;
    logic [4:0]         row;
    logic [4:0]         col;
    logic [12:0]        flat;
    logic signed [39:0] val;
    logic               last;
  } conv_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = c2dv_pkg::ACT_WEIGHT;
  logic [7:0] weight_addr = 8'd0;
  logic signed [15:0] data_value = 16'sd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] filter_num;
  logic [4:0] out_row;
  logic [4:0] out_col;
  logic [12:0] flat_index;
  logic signed [39:0] result_value;
  logic last_of_run;

  conv2d_valid_multi_filter_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .weight_addr(weight_addr), .data_value(data_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .filter_num(filter_num), .out_row(out_row), .out_col(out_col),
    .flat_index(flat_index), .result_value(result_value), .last_of_run(last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] kern_mem [NW];
  logic signed [15:0] bias_mem [NF];
  logic signed [15:0] line_mem [(KS - 1) * IMG];
  logic signed [15:0] win_mem [KS * KS];
  int pix_r;
  int pix_c;

  word_t stim_q[$];
  conv_res_t conv_q[$];
  word_t cur;
  int send_idle;
  int recv_stall;
  int hold_left;
  bit hold_req;
  int errors;
  int cycles;

  task automatic convolve_word(input word_t w);
    logic signed [15:0] column [KS];
    longint acc;
    conv_res_t r;
    int orow;
    int ocol;
    case (w.act)
      c2dv_pkg::ACT_WEIGHT: begin
        if (w.addr < NW) kern_mem[w.addr] = w.data;
      end
      c2dv_pkg::ACT_BIAS: begin
        if (w.addr < NF) bias_mem[w.addr] = w.data;
      end
      c2dv_pkg::ACT_PIXEL: begin
        for (int i = 0; i < KS - 1; i++) column[i] = line_mem[i * IMG + pix_c];
        column[KS - 1] = w.data;
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS - 1; j++) win_mem[i * KS + j] = win_mem[i * KS + j + 1];
          win_mem[i * KS + KS - 1] = column[i];
        end
        for (int i = 0; i < KS - 1; i++) line_mem[i * IMG + pix_c] = column[i + 1];
        if (pix_r >= KS - 1 && pix_c >= KS - 1) begin
          orow = pix_r - (KS - 1);
          ocol = pix_c - (KS - 1);
          for (int f = 0; f < NF; f++) begin
            acc = longint'(bias_mem[f]) * 4096;
            for (int i = 0; i < KS * KS; i++)
              acc += longint'(win_mem[i]) * longint'(kern_mem[f * KS * KS + i]);
            r.filt = 3'(f);
            r.row = 5'(orow);
            r.col = 5'(ocol);
            r.flat = 13'(f * OD * OD + orow * OD + ocol);
            r.val = acc[39:0];
            r.last = (f == NF - 1);
            conv_q.push_back(r);
          end
        end
        if (pix_c + 1 >= IMG) begin
          pix_c = 0;
          pix_r = (pix_r + 1 >= IMG) ? 0 : pix_r + 1;
        end else begin
          pix_c = pix_c + 1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_data();
    int p;
    p = $urandom_range(99);
    if (p < 4) return 16'h7fff;
    if (p < 8) return 16'h8000;
    if (p < 10) return 16'h0000;
    if (p < 12) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int p;
    p = $urandom_range(99);
    w.data = rand_data();
    w.addr = 8'($urandom);
    if (p < 86) begin
      w.act = c2dv_pkg::ACT_PIXEL;
    end else if (p < 92) begin
      w.act = c2dv_pkg::ACT_WEIGHT;
    end else if (p < 96) begin
      w.act = c2dv_pkg::ACT_BIAS;
      if (p < 95) w.addr = 8'($urandom_range(15));
    end else begin
      w.act = ACT_NONE;
    end
    return w;
  endfunction

  // word sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) convolve_word(cur);
      if (!in_valid || in_ready) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur = stim_q.pop_front();
          in_valid <= 1'b1;
          action <= cur.act;
          weight_addr <= cur.addr;
          data_value <= cur.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    conv_res_t e;
    conv_res_t a;
    if (!rst && out_valid && out_ready) begin
      a = '{filter_num, out_row, out_col, flat_index, result_value, last_of_run};
      if (conv_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", a);
      end else begin
        e = conv_q.pop_front();
        if (a !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain_words();
    while (stim_q.size() > 0 || in_valid) @(posedge clk);
  endtask

  task automatic run_phase(input int si, input int rs, input int n);
    @(negedge clk);
    send_idle = si;
    recv_stall = rs;
    repeat (n) stim_q.push_back(rand_word());
    drain_words();
  endtask

  word_t edge_rows [] = '{
    '{c2dv_pkg::ACT_WEIGHT, 8'd0,   16'h7fff},
    '{c2dv_pkg::ACT_WEIGHT, 8'd199, 16'h8000},
    '{c2dv_pkg::ACT_WEIGHT, 8'd200, 16'h1234},
    '{c2dv_pkg::ACT_WEIGHT, 8'd255, 16'hffff},
    '{c2dv_pkg::ACT_BIAS,   8'd0,   16'h8000},
    '{c2dv_pkg::ACT_BIAS,   8'd7,   16'h7fff},
    '{c2dv_pkg::ACT_BIAS,   8'd8,   16'h5555},
    '{c2dv_pkg::ACT_BIAS,   8'd255, 16'haaaa},
    '{ACT_NONE,             8'd255, 16'hffff},
    '{ACT_NONE,             8'd0,   16'h0000},
    '{c2dv_pkg::ACT_PIXEL,  8'd255, 16'h7fff},
    '{c2dv_pkg::ACT_PIXEL,  8'd0,   16'h8000},
    '{c2dv_pkg::ACT_PIXEL,  8'haa,  16'hffff},
    '{c2dv_pkg::ACT_PIXEL,  8'h55,  16'h0000},
    '{c2dv_pkg::ACT_PIXEL,  8'd1,   16'h0001}
  };

  initial begin
    word_t w;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    pix_r = 0;
    pix_c = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win_mem[i]) win_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every weight and bias written before any window completes
    for (int i = 0; i < NW; i++) begin
      w = '{c2dv_pkg::ACT_WEIGHT, 8'(i), rand_data()};
      stim_q.push_back(w);
    end
    for (int i = 0; i < NF; i++) begin
      w = '{c2dv_pkg::ACT_BIAS, 8'(i), rand_data()};
      stim_q.push_back(w);
    end
    foreach (edge_rows[i]) stim_q.push_back(edge_rows[i]);
    drain_words();

    // long receiver hold-off while pixels keep coming
    for (int i = 0; i < 130; i++) begin
      w = '{c2dv_pkg::ACT_PIXEL, 8'($urandom), rand_data()};
      stim_q.push_back(w);
    end
    @(negedge clk);
    hold_req = 1'b1;
    drain_words();

    run_phase(74, 0, 30);
    run_phase(0, 74, 30);
    run_phase(11, 11, 30);
    run_phase(0, 0, 30);

    while (conv_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && conv_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/c2dv_pkg.sv
rtl/core/c2dv_mac.sv
rtl/core/conv2d_valid_multi_filter_core.sv
sim/conv2d_valid_multi_filter_core_tb.sv
